// ----- rtl/core/bas_pkg.sv -----
`default_nettype none
package bas_pkg;

  // Opcodes
  localparam logic OP_SUB = 1'b0;
  localparam logic OP_DAA = 1'b1;

  // Flag bit positions
  localparam int unsigned FLAG_S  = 7;
  localparam int unsigned FLAG_Z  = 6;
  localparam int unsigned FLAG_Y  = 5;
  localparam int unsigned FLAG_H  = 4;
  localparam int unsigned FLAG_X  = 3;
  localparam int unsigned FLAG_PV = 2;
  localparam int unsigned FLAG_N  = 1;
  localparam int unsigned FLAG_C  = 0;

  // Decimal adjust corrections
  localparam logic [7:0] ADJ_NONE   = 8'h00;
  localparam logic [7:0] ADJ_ADD_LO = 8'h06;
  localparam logic [7:0] ADJ_ADD_HI = 8'h60;
  localparam logic [7:0] ADJ_ADD_BO = 8'h66;
  localparam logic [7:0] ADJ_SUB_LO = 8'hFA;
  localparam logic [7:0] ADJ_SUB_HI = 8'hA0;
  localparam logic [7:0] ADJ_SUB_BO = 8'h9A;

  typedef struct packed {
    logic       opcode;
    logic [7:0] acc;
    logic [7:0] operand;
    logic [7:0] flags_in;
  } req_t;

  typedef struct packed {
    logic [7:0] result;
    logic [7:0] flags_out;
  } rsp_t;

endpackage
`default_nettype wire

// ----- rtl/core/bas_alu.sv -----
`default_nettype none
module bas_alu (
  input  bas_pkg::req_t req,
  output bas_pkg::rsp_t rsp
);
  import bas_pkg::*;

  logic [8:0] diff;
  logic [7:0] sub_res;
  logic [7:0] sub_flg;
  logic [3:0] hi;
  logic [3:0] lo;
  logic       c;
  logic       h;
  logic       newc;
  logic       newh;
  logic [7:0] adj;
  logic [7:0] daa_res;
  logic [7:0] daa_flags;

  // Subtract / compare
  always_comb begin
    diff    = {1'b0, req.acc} - {1'b0, req.operand};
    sub_res = diff[7:0];
    sub_flg = req.flags_in & 8'h28;
    sub_flg[FLAG_S]  = sub_res[7];
    sub_flg[FLAG_Z]  = (sub_res == 8'h00);
    sub_flg[FLAG_H]  = (req.acc[3:0] < req.operand[3:0]);
    sub_flg[FLAG_PV] = (req.acc[7] != req.operand[7]) && (sub_res[7] != req.acc[7]);
    sub_flg[FLAG_N]  = 1'b1;
    sub_flg[FLAG_C]  = diff[8];
  end

  // Decimal adjust: pick the correction, priority order decides
  always_comb begin
    hi   = req.acc[7:4];
    lo   = req.acc[3:0];
    c    = req.flags_in[FLAG_C];
    h    = req.flags_in[FLAG_H];
    adj  = ADJ_NONE;
    newc = c;
    newh = h;
    if (!req.flags_in[FLAG_N]) begin
      priority if (!c && !h && hi < 4'hA && lo < 4'hA) begin
        adj = ADJ_NONE;
      end else if (!c && !h && hi < 4'h9 && lo > 4'h9) begin
        adj = ADJ_ADD_LO;
      end else if (!c && h && hi < 4'hA && lo < 4'h4) begin
        adj = ADJ_ADD_LO;
      end else if (!c && !h && hi > 4'h9 && lo < 4'hA) begin
        adj  = ADJ_ADD_HI;
        newc = 1'b1;
      end else if (!c && !h && hi > 4'h8 && lo > 4'h9) begin
        adj  = ADJ_ADD_BO;
        newc = 1'b1;
      end else if (!c && h && hi > 4'h9 && lo < 4'h4) begin
        adj  = ADJ_ADD_BO;
        newc = 1'b1;
      end else if (c && !h && hi < 4'h3 && lo < 4'hA) begin
        adj = ADJ_ADD_HI;
      end else if (c && !h && hi < 4'h3 && lo > 4'h9) begin
        adj = ADJ_ADD_BO;
      end else if (c && h && hi < 4'h4 && lo < 4'h4) begin
        adj = ADJ_ADD_BO;
      end else begin
        adj = ADJ_NONE;
      end
      newh = (lo > 4'h9);
    end else begin
      priority if (!c && !h && hi < 4'hA && lo < 4'hA) begin
        adj = ADJ_NONE;
      end else if (!c && h && hi < 4'h9 && lo > 4'h5) begin
        adj = ADJ_SUB_LO;
      end else if (c && !h && hi > 4'h6 && lo < 4'hA) begin
        adj = ADJ_SUB_HI;
      end else if (c && h && hi > 4'h5 && lo > 4'h5) begin
        adj = ADJ_SUB_BO;
      end else begin
        adj = ADJ_NONE;
      end
      if (h && lo > 4'h5) begin
        newh = 1'b0;
      end
    end
    daa_res   = req.acc + adj;
    daa_flags = req.flags_in & 8'h2A;
    daa_flags[FLAG_S]  = daa_res[7];
    daa_flags[FLAG_Z]  = (daa_res == 8'h00);
    daa_flags[FLAG_H]  = newh;
    daa_flags[FLAG_PV] = ~^daa_res;
    daa_flags[FLAG_C]  = newc;
  end

  always_comb begin
    unique case (req.opcode)
      OP_SUB: begin
        rsp.result    = sub_res;
        rsp.flags_out = sub_flg;
      end
      OP_DAA: begin
        rsp.result    = daa_res;
        rsp.flags_out = daa_flags;
      end
      default: begin
        rsp.result    = sub_res;
        rsp.flags_out = sub_flg;
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/core/bcd_adjust_and_subtract_flags.sv -----
`default_nettype none
// Subtract-flag and decimal-adjust unit for an 8-bit accumulator datapath.
// Present a request on req with start high; it is taken whenever busy is
// low, and busy is never raised, so a new request can enter every cycle.
// The answer appears on rsp qualified by done for exactly one cycle:
// one register captures the request, a short block of logic computes the
// difference or the BCD correction plus flags, and a second register holds
// the answer. There is no back pressure on the result side - capture rsp
// in the cycle done is high or it is gone. Throughput is one request per
// clock; the answer passes the request register and then the result
// register. Flag bits 5 and 3 pass through.
module bcd_adjust_and_subtract_flags (
  input  wire           clk,
  input  wire           rst,
  input  wire           start,
  output logic          busy,
  input  bas_pkg::req_t req,
  output logic          done,
  output bas_pkg::rsp_t rsp
);
  import bas_pkg::*;

  req_t req_q;
  logic req_vld;
  rsp_t alu_rsp;

  // Never stall: every stage advances each cycle.
  assign busy = 1'b0;

  // Capture the request.
  always_ff @(posedge clk) begin
    if (rst) begin
      req_vld <= 1'b0;
    end else begin
      req_vld <= start && !busy;
    end
    req_q <= req;
  end

  bas_alu u_alu (
    .req (req_q),
    .rsp (alu_rsp)
  );

  // Hold the answer for one cycle, flagged by done.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= req_vld;
    end
    rsp <= alu_rsp;
  end

endmodule
`default_nettype wire

// ----- rtl/core/bas_chk.sv -----
`default_nettype none
module bas_chk (
  input wire           clk,
  input wire           rst,
  input wire           start,
  input wire           busy,
  input bas_pkg::req_t req,
  input wire           done,
  input bas_pkg::rsp_t rsp
);
  import bas_pkg::*;

  a_no_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy raised");

  a_done_from_req: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, 2))
    else $error("done without a request two cycles earlier");

  a_sub_n: assert property (@(posedge clk) disable iff (rst)
    done && $past(req.opcode, 2) == OP_SUB |-> rsp.flags_out[FLAG_N])
    else $error("subtract result without N");

  a_passthru: assert property (@(posedge clk) disable iff (rst)
    done |-> rsp.flags_out[FLAG_Y] == $past(req.flags_in[FLAG_Y], 2) &&
             rsp.flags_out[FLAG_X] == $past(req.flags_in[FLAG_X], 2))
    else $error("bits 5/3 not passed through");

  a_zero: assert property (@(posedge clk) disable iff (rst)
    done |-> rsp.flags_out[FLAG_Z] == (rsp.result == 8'h00))
    else $error("Z flag disagrees with result");

endmodule

bind bcd_adjust_and_subtract_flags bas_chk u_bas_chk (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .req   (req),
  .done  (done),
  .rsp   (rsp)
);
`default_nettype wire

// ----- dv/bcd_adjust_and_subtract_flags_test.sv -----
`timescale 1ns / 1ps

module bcd_adjust_and_subtract_flags_test;
  import bas_pkg::*;

  // Single-bit flag masks, built from the package bit positions.
  localparam logic [7:0] MASK_S  = 8'b1 << FLAG_S;
  localparam logic [7:0] MASK_Z  = 8'b1 << FLAG_Z;
  localparam logic [7:0] MASK_Y  = 8'b1 << FLAG_Y;
  localparam logic [7:0] MASK_H  = 8'b1 << FLAG_H;
  localparam logic [7:0] MASK_X  = 8'b1 << FLAG_X;
  localparam logic [7:0] MASK_PV = 8'b1 << FLAG_PV;
  localparam logic [7:0] MASK_N  = 8'b1 << FLAG_N;
  localparam logic [7:0] MASK_C  = 8'b1 << FLAG_C;

  // Cycles in a row with neither a request nor an answer before giving up.
  // Honest traffic never idles for longer than the largest drawn request gap
  // plus the trip through the pipeline, so this is generous.
  localparam int unsigned STALL_LIMIT = 200;

  logic  clk;
  logic  rst;
  logic  start;
  logic  busy;
  req_t  req;
  logic  done;
  rsp_t  rsp;

  rsp_t        pending_answers[$];
  int unsigned error_count;
  int unsigned stall_cycles;
  bit          burst_mode;

  bcd_adjust_and_subtract_flags dut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .req   (req),
    .done  (done),
    .rsp   (rsp)
  );

  always #5 clk = ~clk;

  // Predict the result byte and the new flag byte of one request.
  function automatic rsp_t predict_answer(input req_t r);
    logic [7:0] a;
    logic [7:0] fin;
    logic [7:0] adj;
    logic [7:0] res;
    logic [7:0] f;
    logic [3:0] hi;
    logic [3:0] lo;
    logic       c;
    logic       h;
    logic       nc;
    logic       nh;
    rsp_t       ans;
    a   = r.acc;
    fin = r.flags_in;
    if (r.opcode == OP_SUB) begin
      res = a - r.operand;
      // Keep the undocumented bits 5 and 3, rebuild everything else.
      f = fin & (MASK_Y | MASK_X);
      f[FLAG_S]  = res[7];
      f[FLAG_Z]  = (res == 8'h00);
      f[FLAG_C]  = (a < r.operand);
      f[FLAG_H]  = (a[3:0] < r.operand[3:0]);
      f[FLAG_PV] = (a[7] != r.operand[7]) && (res[7] != a[7]);
      f[FLAG_N]  = 1'b1;
    end else begin
      hi  = a[7:4];
      lo  = a[3:0];
      c   = fin[FLAG_C];
      h   = fin[FLAG_H];
      adj = ADJ_NONE;
      nc  = c;
      nh  = h;
      if (!fin[FLAG_N]) begin
        // Correction table after an addition; unlisted rows add nothing.
        if (!c && !h && hi < 4'hA && lo < 4'hA) begin
          adj = ADJ_NONE;
        end else if (!c && !h && hi < 4'h9 && lo > 4'h9) begin
          adj = ADJ_ADD_LO;
        end else if (!c && h && hi < 4'hA && lo < 4'h4) begin
          adj = ADJ_ADD_LO;
        end else if (!c && !h && hi > 4'h9 && lo < 4'hA) begin
          adj = ADJ_ADD_HI;
          nc  = 1'b1;
        end else if (!c && !h && hi > 4'h8 && lo > 4'h9) begin
          adj = ADJ_ADD_BO;
          nc  = 1'b1;
        end else if (!c && h && hi > 4'h9 && lo < 4'h4) begin
          adj = ADJ_ADD_BO;
          nc  = 1'b1;
        end else if (c && !h && hi < 4'h3 && lo < 4'hA) begin
          adj = ADJ_ADD_HI;
        end else if (c && !h && hi < 4'h3 && lo > 4'h9) begin
          adj = ADJ_ADD_BO;
        end else if (c && h && hi < 4'h4 && lo < 4'h4) begin
          adj = ADJ_ADD_BO;
        end
        nh = (lo > 4'h9);
      end else begin
        // Correction table after a subtraction; carry is never touched.
        if (!c && !h && hi < 4'hA && lo < 4'hA) begin
          adj = ADJ_NONE;
        end else if (!c && h && hi < 4'h9 && lo > 4'h5) begin
          adj = ADJ_SUB_LO;
        end else if (c && !h && hi > 4'h6 && lo < 4'hA) begin
          adj = ADJ_SUB_HI;
        end else if (c && h && hi > 4'h5 && lo > 4'h5) begin
          adj = ADJ_SUB_BO;
        end
        if (h && lo > 4'h5) begin
          nh = 1'b0;
        end
      end
      res = a + adj;
      f = fin & (MASK_Y | MASK_X | MASK_N);
      f[FLAG_C]  = nc;
      f[FLAG_H]  = nh;
      f[FLAG_PV] = ~^res;
      f[FLAG_S]  = res[7];
      f[FLAG_Z]  = (res == 8'h00);
    end
    ans.result    = res;
    ans.flags_out = f;
    return ans;
  endfunction

  // Present one request, hold it until the block takes it, record the
  // prediction, then idle for a drawn number of cycles. With a zero gap
  // start stays high so the next request follows back to back.
  task automatic issue_request(input logic op, input logic [7:0] a,
                               input logic [7:0] b, input logic [7:0] fl);
    req_t        item;
    int unsigned gap;
    item.opcode   = op;
    item.acc      = a;
    item.operand  = b;
    item.flags_in = fl;
    gap = burst_mode ? 0 : $urandom_range(0, 8);
    req   <= item;
    start <= 1'b1;
    @(posedge clk);
    while (busy) begin
      @(posedge clk);
    end
    pending_answers.push_back(predict_answer(item));
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop start and wait for every outstanding answer to come back.
  task automatic hold_requests();
    start <= 1'b0;
    while (pending_answers.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Bias toward the bytes where borrows, overflow and BCD limits sit.
  function automatic logic [7:0] corner_byte();
    logic [7:0] picks[8];
    picks = '{8'h00, 8'hFF, 8'h7F, 8'h80, 8'h09, 8'h0A, 8'h99, 8'h9A};
    if ($urandom_range(0, 7) == 0) begin
      return picks[$urandom_range(0, 7)];
    end
    return 8'($urandom);
  endfunction

  // Subtract: zero, borrow out of both nibbles, signed overflow both ways,
  // and pass-through of bits 5 and 3 with all-ones and all-zeros flags.
  task automatic test_subtract_corners();
    issue_request(OP_SUB, 8'h00, 8'h00, 8'h00);
    issue_request(OP_SUB, 8'h00, 8'h01, 8'hFF);
    issue_request(OP_SUB, 8'h80, 8'h01, MASK_Y);
    issue_request(OP_SUB, 8'h7F, 8'hFF, MASK_X);
    issue_request(OP_SUB, 8'hFF, 8'h00, 8'h00);
    issue_request(OP_SUB, 8'h10, 8'h01, 8'hFF);
    issue_request(OP_SUB, 8'hFF, 8'hFF, 8'h00);
  endtask

  // Adjust after an addition: walk every row of the correction table,
  // then a C+H combination that falls outside it.
  task automatic test_adjust_after_add();
    issue_request(OP_DAA, 8'h99, 8'h00, 8'h00);
    issue_request(OP_DAA, 8'h0A, 8'hFF, MASK_Y);
    issue_request(OP_DAA, 8'h93, 8'h00, MASK_H);
    issue_request(OP_DAA, 8'hA5, 8'h00, MASK_X);
    issue_request(OP_DAA, 8'h9B, 8'h00, 8'h00);
    issue_request(OP_DAA, 8'hA2, 8'h00, MASK_H | MASK_S | MASK_Z);
    issue_request(OP_DAA, 8'h25, 8'h00, MASK_C);
    issue_request(OP_DAA, 8'h2C, 8'h00, MASK_C | MASK_PV);
    issue_request(OP_DAA, 8'h33, 8'h00, MASK_C | MASK_H);
    issue_request(OP_DAA, 8'hF5, 8'h00, MASK_C | MASK_H);
  endtask

  // Adjust after a subtraction: each correction, an unlisted combination,
  // and H kept when the low nibble is 5 or less.
  task automatic test_adjust_after_subtract();
    issue_request(OP_DAA, 8'h45, 8'h00, MASK_N);
    issue_request(OP_DAA, 8'h37, 8'h00, MASK_N | MASK_H);
    issue_request(OP_DAA, 8'h85, 8'h00, MASK_N | MASK_C);
    issue_request(OP_DAA, 8'h77, 8'h00, MASK_N | MASK_C | MASK_H);
    issue_request(OP_DAA, 8'hAF, 8'h00, MASK_N | MASK_Y | MASK_X);
    issue_request(OP_DAA, 8'h34, 8'h00, MASK_N | MASK_H);
  endtask

  // Random mix of both opcodes. Switch between bursts with no idling and
  // stretches of random gaps every few dozen requests.
  task automatic test_random_traffic(input int unsigned count);
    logic       op;
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] fl;
    for (int unsigned i = 0; i < count; i++) begin
      if (i % 50 == 0) begin
        burst_mode = ($urandom_range(0, 3) == 0);
      end
      op = 1'($urandom);
      a  = corner_byte();
      b  = corner_byte();
      fl = 8'($urandom);
      // Half of the adjust requests carry packed-BCD-ish accumulators so
      // the in-range rows of both tables get plenty of hits.
      if (op == OP_DAA && $urandom_range(0, 1) == 0) begin
        a = {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
      end
      issue_request(op, a, b, fl);
    end
    burst_mode = 1'b0;
  endtask

  // Stop sending until the pipeline has fully drained, then resume.
  task automatic test_drain_pause();
    issue_request(OP_SUB, 8'h5A, 8'hA5, 8'h00);
    issue_request(OP_DAA, 8'h9A, 8'h00, 8'h00);
    hold_requests();
    issue_request(OP_SUB, 8'hA5, 8'h5A, 8'hFF);
  endtask

  // Compare each answer, field by field, with the oldest prediction.
  always @(posedge clk) begin
    rsp_t want;
    if (!rst && done) begin
      if (pending_answers.size() == 0) begin
        $error("answer %h/%h arrived with no request pending",
               rsp.result, rsp.flags_out);
        error_count++;
      end else begin
        want = pending_answers.pop_front();
        if (rsp.result !== want.result) begin
          $error("result mismatch: expected %h, actual %h", want.result, rsp.result);
          error_count++;
        end
        if (rsp.flags_out !== want.flags_out) begin
          $error("flags_out mismatch: expected %b, actual %b",
                 want.flags_out, rsp.flags_out);
          error_count++;
        end
      end
    end
  end

  // Watchdog: end the run if nothing moves for too long.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    clk          = 1'b0;
    rst          = 1'b1;
    start        = 1'b0;
    req          = '0;
    error_count  = 0;
    stall_cycles = 0;
    burst_mode   = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_subtract_corners();
    test_adjust_after_add();
    test_adjust_after_subtract();
    test_random_traffic(800);
    test_drain_pause();
    test_random_traffic(950);

    // Drain, then keep clocking the two-stage pipeline so any stray answer
    // still shows up.
    hold_requests();
    repeat (4) @(posedge clk);
    if (pending_answers.size() != 0) begin
      $error("%0d answers never arrived", pending_answers.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/bas_pkg.sv
rtl/core/bas_alu.sv
rtl/core/bcd_adjust_and_subtract_flags.sv
rtl/core/bas_chk.sv
dv/bcd_adjust_and_subtract_flags_test.sv
